// File: rtl/deq_pkg.sv
// shared types, constants and the ring index helper for the double-ended queue
// no dependencies
`default_nettype none

package deq_pkg;

   localparam int CAPACITY = 256;
   localparam int DATA_W   = 32;
   localparam int POS_W    = 8;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int OPC_W    = 3;
   localparam int STS_W    = 2;
   localparam int OUT_CNT_W = 9;

   typedef enum logic [OPC_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_REAR  = 3'd1,
      OP_READ_INDEX = 3'd2,
      OP_READ_FRONT = 3'd3,
      OP_READ_BACK  = 3'd4
   } opcode_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
   } dp_cmd_type;

   // (base + off) wrapped into the ring; the wrap is exact only while off does not exceed CAPACITY
   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/deq_ram.sv
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: rtl/deq_ctrl.sv
// handshake sequencer for the double-ended queue
// depends on deq_pkg
`default_nettype none

module deq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output deq_pkg::dp_cmd_type      cmd
);

   import deq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready) begin
               state_in = req_tvalid ? ST_LOAD : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd.load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
         end
         ST_HOLD: begin
            rsp_tvalid = 1'b1;
            // a new beat may enter as the result leaves
            req_tready = rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
      cmd.accept = req_tvalid & req_tready;
   end

endmodule

`default_nettype wire

// File: rtl/deq_dpath.sv
// ring store, head pointer, count and result registers of the double-ended queue
// depends on deq_pkg and deq_ram
`default_nettype none

module deq_dpath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire deq_pkg::dp_cmd_type            cmd,
   input  wire logic [deq_pkg::OPC_W-1:0]      opcode,
   input  wire logic [deq_pkg::DATA_W-1:0]     value,
   input  wire logic [deq_pkg::POS_W-1:0]      position,
   output logic      [deq_pkg::DATA_W-1:0]     read_data,
   output logic      [deq_pkg::STS_W-1:0]      status,
   output logic      [deq_pkg::OUT_CNT_W-1:0]  element_count,
   output logic                                is_empty
);

   import deq_pkg::*;

   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   status_type        status_ff, status_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [DATA_W-1:0] data_ff;

   logic [ADDR_W-1:0] ram_addr;
   logic              ram_we;
   logic [DATA_W-1:0] ram_rdata;

   logic              full;
   logic              empty;
   logic [ADDR_W-1:0] head_dec;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? ADDR_W'(CAPACITY - 1) : head_ff - ADDR_W'(1);

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      status_in = STS_OK;
      rd_ok_in  = 1'b0;
      ram_addr  = head_ff;
      ram_we    = 1'b0;
      unique case (opcode_type'(opcode))
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               ram_addr = head_dec;
               ram_we   = cmd.accept;
               head_in  = head_dec;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_REAR: begin
            if (full) begin
               status_in = STS_FULL;
            end else begin
               ram_addr = ring_add(head_ff, count_ff);
               ram_we   = cmd.accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_READ_INDEX: begin
            ram_addr = ring_add(head_ff, CNT_W'(position));
            if (CMP_W'(position) < CMP_W'(count_ff)) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = STS_RANGE;
            end
         end
         OP_READ_FRONT: begin
            if (!empty) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = STS_RANGE;
            end
         end
         OP_READ_BACK: begin
            ram_addr = ring_add(head_ff, count_ff - CNT_W'(1));
            if (!empty) begin
               rd_ok_in = 1'b1;
            end else begin
               status_in = STS_RANGE;
            end
         end
         default: begin
            status_in = STS_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         status_ff <= status_in;
         rd_ok_ff  <= rd_ok_in;
      end
      // ram read data lands in the cycle after the accepting beat
      if (cmd.load) begin
         data_ff <= rd_ok_ff ? ram_rdata : '0;
      end
   end

   deq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (value),
      .rdata (ram_rdata)
   );

   assign read_data     = data_ff;
   assign status        = status_ff;
   assign element_count = OUT_CNT_W'(count_ff);
   assign is_empty      = (count_ff == '0);

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// bounded double-ended queue: ring store with head pointer and element count
// an accepted request beat passes the load state, then the result beat is offered (store read is registered)
// no new request is taken during the load state, set by the registered store read before the result
// a new request is taken in the same cycle the pending result is taken
// reset: synchronous, clears head pointer, count and handshake state; the store keeps
// its contents, and only data read from written entries reaches a result
`default_nettype none

module double_ended_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // value[31:0], position[39:32]
   input  wire logic [2:0]  req_tuser,   // opcode[2:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [47:0] rsp_tdata    // read_data[31:0], status[33:32],
                                         // element_count[42:34], is_empty[43], zero[47:44]
);

   import deq_pkg::*;

   dp_cmd_type             cmd;
   logic [DATA_W-1:0]      read_data;
   logic [STS_W-1:0]       status;
   logic [OUT_CNT_W-1:0]   element_count;
   logic                   is_empty;

   deq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   deq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .opcode        (req_tuser),
      .value         (req_tdata[31:0]),
      .position      (req_tdata[39:32]),
      .read_data     (read_data),
      .status        (status),
      .element_count (element_count),
      .is_empty      (is_empty)
   );

   assign rsp_tdata = {4'b0000, is_empty, element_count, status, read_data};

endmodule

`default_nettype wire
